>>> rtl/kmh_pkg.sv
// ----------------------------------------------------------------------------
// kmh_pkg
// Types and constants shared by the k-mer MinHash sketch update block.
// ----------------------------------------------------------------------------
package kmh_pkg;

    localparam logic [1:0] REQ_BASE  = 2'd0;
    localparam logic [1:0] REQ_HASH  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic [1:0] CFG_KMER_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_HASH_SEED    = 2'd1;
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

    localparam logic [5:0]  KMER_LENGTH_RESET  = 6'd21;
    localparam logic [10:0] BUCKET_COUNT_RESET = 11'd1024;
    localparam logic [5:0]  MAX_KMER           = 6'd32;

    localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int          FMIX_SHIFT = 33;
    localparam int          KEY_SHIFT  = 11;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  base_char;
        logic        seq_start;
        logic [63:0] hash_value;
        logic [9:0]  read_index;
    } kmh_in_t;

    typedef struct packed {
        logic [52:0] bucket_key;
        logic        bucket_filled;
        logic [10:0] filled_buckets;
    } kmh_out_t;

    typedef enum logic [1:0] {
        OP_CANON,
        OP_DIRECT,
        OP_READ
    } kmh_op_kind_t;

    typedef struct packed {
        kmh_op_kind_t kind;
        logic [63:0]  value;
        logic [9:0]   idx;
    } kmh_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kmh_q_stat_t;

    typedef struct packed {
        logic clearing;
    } kmh_back_stat_t;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_MUL,
        B_SHIFT,
        B_BKT0,
        B_BKT1,
        B_UPD,
        B_RDOUT
    } kmh_bstate_t;

endpackage

>>> rtl/kmer_minhash_sketch_update.sv
// ----------------------------------------------------------------------------
// kmer_minhash_sketch_update
// One-permutation MinHash sketch over DNA k-mers with bucket read-back.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid, in_ready, in_data      | item in
//  out     | out_valid, out_ready, out_data   | item out (bucket reads only)
//  cfg     | cfg_valid, cfg_ready, cfg_index, | register write
//          | cfg_data                         |
//
//  A canonical k-mer insert runs three fmix rounds in the back end and a
//  direct insert two, each of six partial products on the shared 32x32
//  multiplier; a read only fetches its bucket from the bucket memory.
//  After reset all MAX_BUCKETS buckets of the memory are cleared with
//  in_ready low; cfg writes are taken throughout.
//  A two-entry queue lets the front accept while the back works or out stalls.
// ----------------------------------------------------------------------------
module kmer_minhash_sketch_update
    import kmh_pkg::*;
#(
    parameter int MAX_BUCKETS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  kmh_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output kmh_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [5:0]  kmer_length_reg;
    logic [63:0] hash_seed_reg;
    logic [10:0] bucket_count_reg;

    logic           push;
    logic           pop;
    kmh_op_t        push_op;
    kmh_op_t        head;
    kmh_q_stat_t    q_stat;
    kmh_back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg  <= KMER_LENGTH_RESET;
            hash_seed_reg    <= '0;
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                CFG_KMER_LENGTH:  kmer_length_reg  <= cfg_data[5:0];
                CFG_HASH_SEED:    hash_seed_reg    <= cfg_data;
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data[10:0];
                default:          hash_seed_reg    <= hash_seed_reg;
            endcase
        end
    end

    kmh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .kmer_length (kmer_length_reg),
        .q_stat      (q_stat),
        .back_stat   (back_stat),
        .push        (push),
        .push_op     (push_op)
    );

    kmh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    kmh_back #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hash_seed    (hash_seed_reg),
        .bucket_count (bucket_count_reg),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .back_stat    (back_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> !in_ready)
        else $error("item taken during bucket clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.bucket_filled) |-> (out_data.bucket_key == 53'd0))
        else $error("empty bucket reported with a key");

endmodule

>>> rtl/kmh_front.sv
// ----------------------------------------------------------------------------
// kmh_front
// Accepts items, rolls the forward and reverse-complement k-mers, and queues
// hash inserts and bucket reads for the back end.
// ----------------------------------------------------------------------------
module kmh_front
    import kmh_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  kmh_in_t        in_data,
    input  logic [5:0]     kmer_length,
    input  kmh_q_stat_t    q_stat,
    input  kmh_back_stat_t back_stat,
    output logic           push,
    output kmh_op_t        push_op
);

    logic [63:0] fwd_reg, fwd_next;
    logic [63:0] rev_reg, rev_next;
    logic [31:0] flags_reg, flags_next;
    logic [5:0]  fill_reg, fill_next;

    logic [5:0]  k;
    logic [63:0] kmask;
    logic [31:0] fmask;
    logic [1:0]  fc;
    logic [1:0]  rc;
    logic        bad;
    logic [63:0] fwd_base, rev_base;
    logic [31:0] flags_base;
    logic [5:0]  fill_base;
    logic        accept;
    logic        hash_ok;

    assign in_ready = !back_stat.clearing && !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (kmer_length == 6'd0)
        begin
            k = 6'd1;
        end
        else if (kmer_length > MAX_KMER)
        begin
            k = MAX_KMER;
        end
        else
        begin
            k = kmer_length;
        end
    end

    always_comb
    begin
        if (k == MAX_KMER)
        begin
            kmask = '1;
            fmask = '1;
        end
        else
        begin
            kmask = (64'd1 << {k, 1'b0}) - 64'd1;
            fmask = (32'd1 << k) - 32'd1;
        end
    end

    always_comb
    begin
        bad = 1'b0;
        fc  = 2'd0;
        unique case (in_data.base_char)
            8'h41, 8'h61: fc = 2'd0;
            8'h43, 8'h63: fc = 2'd1;
            8'h47, 8'h67: fc = 2'd2;
            8'h54, 8'h74: fc = 2'd3;
            default:      bad = 1'b1;
        endcase
        rc = bad ? 2'd0 : (2'd3 - fc);
    end

    always_comb
    begin
        if (in_data.seq_start)
        begin
            fwd_base   = '0;
            rev_base   = '0;
            flags_base = '0;
            fill_base  = '0;
        end
        else
        begin
            fwd_base   = fwd_reg;
            rev_base   = rev_reg;
            flags_base = flags_reg;
            fill_base  = fill_reg;
        end
    end

    always_comb
    begin
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        flags_next = flags_reg;
        fill_next  = fill_reg;
        if (accept && in_data.req_type == REQ_BASE)
        begin
            fwd_next   = ((fwd_base << 2) | {62'd0, fc}) & kmask;
            rev_next   = ((rev_base >> 2) | ({62'd0, rc} << {k - 6'd1, 1'b0})) & kmask;
            flags_next = {flags_base[30:0], bad};
            fill_next  = (fill_base < MAX_KMER) ? fill_base + 6'd1 : fill_base;
        end
    end

    assign hash_ok = (fill_next >= k) && ((flags_next & fmask) == 32'd0);

    always_comb
    begin
        push          = 1'b0;
        push_op.kind  = OP_CANON;
        push_op.value = (fwd_next <= rev_next) ? fwd_next : rev_next;
        push_op.idx   = in_data.read_index;
        if (accept)
        begin
            priority case (in_data.req_type)
                REQ_BASE:
                begin
                    push = hash_ok;
                end
                REQ_HASH:
                begin
                    push          = 1'b1;
                    push_op.kind  = OP_DIRECT;
                    push_op.value = in_data.hash_value;
                end
                REQ_READ:
                begin
                    push         = 1'b1;
                    push_op.kind = OP_READ;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            rev_reg   <= '0;
            flags_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
            flags_reg <= flags_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

>>> rtl/kmh_queue.sv
// ----------------------------------------------------------------------------
// kmh_queue
// Two-entry queue of operations between the front and back ends.
// ----------------------------------------------------------------------------
module kmh_queue
    import kmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  kmh_op_t     push_op,
    input  logic        pop,
    output kmh_op_t     head,
    output kmh_q_stat_t q_stat
);

    kmh_op_t     entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/kmh_back.sv
// ----------------------------------------------------------------------------
// kmh_back
// Runs seeded fmix rounds on a shared 32x32 multiplier, reduces to a bucket,
// and keeps the minimum key per bucket; answers bucket reads.
// ----------------------------------------------------------------------------
module kmh_back
    import kmh_pkg::*;
#(
    parameter int MAX_BUCKETS = 1024
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    hash_seed,
    input  logic [10:0]    bucket_count,
    input  kmh_op_t        head,
    input  kmh_q_stat_t    q_stat,
    output logic           pop,
    output kmh_back_stat_t back_stat,
    output logic           out_valid,
    input  logic           out_ready,
    output kmh_out_t       out_data
);

    localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = $clog2(MAX_BUCKETS + 1);

    logic [53:0] mem [MAX_BUCKETS];

    kmh_bstate_t state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  step_reg, step_next;
    logic        phase_reg, phase_next;
    logic [1:0]  rnd_reg, rnd_next;
    logic [31:0] h1lo_reg, h1lo_next;
    logic [52:0] key_reg, key_next;
    logic [AW-1:0] bkt_reg, bkt_next;
    logic [53:0] rd_data_reg;
    logic        inrange_reg, inrange_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        out_valid_reg, out_valid_next;
    kmh_out_t    out_reg, out_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] cmul;
    logic [63:0] y;
    logic [63:0] z;
    logic [CW-1:0] m;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [53:0] mem_wdata;

    function automatic logic [63:0] fmix_pre(input logic [63:0] v, input logic [63:0] s);
        logic [63:0] t;
        t = v ^ s;
        return t ^ (t >> FMIX_SHIFT);
    endfunction

    assign back_stat.clearing = (state_reg == B_CLR);
    assign out_valid          = out_valid_reg;
    assign out_data           = out_reg;

    always_comb
    begin
        if (32'(bucket_count) > MAX_BUCKETS)
        begin
            m = CW'(MAX_BUCKETS);
        end
        else if (bucket_count < 11'd2)
        begin
            m = CW'(2);
        end
        else
        begin
            m = CW'(bucket_count);
        end
    end

    assign cmul      = phase_reg ? FMIX_C2 : FMIX_C1;
    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign y         = acc_reg + {prod_reg[31:0], 32'd0};
    assign z         = y ^ (y >> FMIX_SHIFT);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        rnd_next       = rnd_reg;
        h1lo_next      = h1lo_reg;
        key_next       = key_reg;
        bkt_next       = bkt_reg;
        inrange_next   = inrange_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        mul_a          = x_reg[31:0];
        mul_b          = cmul[31:0];
        mem_we         = 1'b0;
        mem_waddr      = bkt_reg;
        mem_wdata      = {1'b1, key_reg};
        mem_raddr      = bkt_reg;

        unique case (state_reg)
            B_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(MAX_BUCKETS - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    x_next     = fmix_pre(head.value, hash_seed);
                    step_next  = 2'd0;
                    phase_next = 1'b0;
                    unique case (head.kind)
                        OP_READ:
                        begin
                            mem_raddr    = AW'(head.idx);
                            bkt_next     = AW'(head.idx);
                            inrange_next = (32'(head.idx) < MAX_BUCKETS);
                            state_next   = B_RDOUT;
                        end
                        OP_CANON:
                        begin
                            rnd_next   = 2'd0;
                            state_next = B_MUL;
                        end
                        OP_DIRECT:
                        begin
                            rnd_next   = 2'd1;
                            state_next = B_MUL;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                unique case (step_reg)
                    2'd0:
                    begin
                        mul_a     = x_reg[31:0];
                        mul_b     = cmul[31:0];
                        step_next = 2'd1;
                    end
                    2'd1:
                    begin
                        mul_a     = x_reg[63:32];
                        mul_b     = cmul[31:0];
                        acc_next  = prod_reg;
                        step_next = 2'd2;
                    end
                    default:
                    begin
                        mul_a      = x_reg[31:0];
                        mul_b      = cmul[63:32];
                        acc_next   = y;
                        step_next  = 2'd0;
                        state_next = B_SHIFT;
                    end
                endcase
            end
            B_SHIFT:
            begin
                if (!phase_reg)
                begin
                    x_next     = z;
                    phase_next = 1'b1;
                    state_next = B_MUL;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (rnd_reg == 2'd2)
                    begin
                        key_next   = z[63:KEY_SHIFT];
                        state_next = B_BKT0;
                    end
                    else
                    begin
                        if (rnd_reg == 2'd1)
                        begin
                            h1lo_next = z[31:0];
                        end
                        x_next     = fmix_pre(z, hash_seed);
                        rnd_next   = rnd_reg + 2'd1;
                        state_next = B_MUL;
                    end
                end
            end
            B_BKT0:
            begin
                mul_a      = h1lo_reg;
                mul_b      = 32'(m);
                state_next = B_BKT1;
            end
            B_BKT1:
            begin
                bkt_next   = AW'(prod_reg[63:32]);
                mem_raddr  = AW'(prod_reg[63:32]);
                state_next = B_UPD;
            end
            B_UPD:
            begin
                if (!rd_data_reg[53])
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else if (key_reg < rd_data_reg[52:0])
                begin
                    mem_we = 1'b1;
                end
                state_next = B_IDLE;
            end
            B_RDOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.bucket_filled  = inrange_reg && rd_data_reg[53];
                    out_next.bucket_key     = (inrange_reg && rd_data_reg[53]) ?
                                              rd_data_reg[52:0] : '0;
                    out_next.filled_buckets = 11'(count_reg);
                    out_valid_next          = 1'b1;
                    state_next              = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        h1lo_reg <= h1lo_next;
        key_reg  <= key_next;
        bkt_reg  <= bkt_next;
        inrange_reg <= inrange_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            rnd_reg       <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            rnd_reg       <= rnd_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
